### rtl/core/dttn_pkg.sv
// Shared types, constants and helpers for the decimal text to number block.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package dttn_pkg;

   // Fixed-point layout and fraction digit limit
   localparam int FRAC_BITS       = 16;
   localparam int MAX_FRAC_DIGITS = 9;
   localparam int STEP_W          = $clog2(FRAC_BITS);
   localparam int INT_W           = 32;
   localparam int FRAC_ACC_W      = 30;
   localparam int FRAC_CNT_W      = 4;
   localparam int VALUE_W         = 48;
   localparam int MAG_W           = 31 + FRAC_BITS;

   localparam logic [INT_W-1:0] INT_MAX_FIXED = 32'h7FFF_FFFF;

   // Format modes
   localparam logic [1:0] MODE_SIGNED   = 2'd0;
   localparam logic [1:0] MODE_UNSIGNED = 2'd1;

   // Character codes
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   typedef struct packed {
      logic [7:0] character;
      logic       end_of_text;
   } req_item_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      integer_overflow;
      logic                      stopped_early;
   } rsp_item_type;

   // Controller to datapath commands
   typedef struct packed {
      logic take_char;
      logic start_div;
      logic div_step;
      logic finish_int;
      logic finish_fixed;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic fixed_mode;
   } status_type;

   // Divisor 10^k for k fraction digits, clamped at 10^9
   function automatic logic [FRAC_ACC_W-1:0] pow10(input logic [FRAC_CNT_W-1:0] k);
      logic [FRAC_ACC_W-1:0] p;
      unique case (k)
         4'd0:    p = 30'd1;
         4'd1:    p = 30'd10;
         4'd2:    p = 30'd100;
         4'd3:    p = 30'd1000;
         4'd4:    p = 30'd10000;
         4'd5:    p = 30'd100000;
         4'd6:    p = 30'd1000000;
         4'd7:    p = 30'd10000000;
         4'd8:    p = 30'd100000000;
         default: p = 30'd1000000000;
      endcase
      return p;
   endfunction

endpackage

### rtl/core/dttn_ctrl.sv
// Controller for the decimal text to number block: accepts characters,
// sequences the fraction divider and owns the result valid flag. Uses dttn_pkg.
`timescale 1ns / 1ps

module dttn_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_end_of_text,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  dttn_pkg::status_type status,
   output dttn_pkg::cmd_type    cmd
);
   import dttn_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              req_xfer;
   logic              last_step;

   // Take characters in idle; hold a terminator while a result is still waiting
   assign req_ready = (state_ff == ST_IDLE) && !(req_end_of_text && rsp_valid_ff);
   assign req_xfer  = req_valid && req_ready;
   assign last_step = (step_ff == STEP_W'(FRAC_BITS - 1));
   assign rsp_valid = rsp_valid_ff;

   // Decode commands
   always_comb begin
      cmd              = '0;
      cmd.take_char    = req_xfer && !req_end_of_text;
      cmd.start_div    = req_xfer && req_end_of_text && status.fixed_mode;
      cmd.finish_int   = req_xfer && req_end_of_text && !status.fixed_mode;
      cmd.div_step     = (state_ff == ST_DIVIDE);
      cmd.finish_fixed = (state_ff == ST_FINISH);
   end

   // Next state
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            if (cmd.start_div) begin
               state_in = ST_DIVIDE;
            end
            if (cmd.finish_int) begin
               rsp_valid_in = 1'b1;
            end
         end
         ST_DIVIDE: begin
            step_in = step_ff + 1'b1;
            if (last_step) begin
               state_in = ST_FINISH;
               step_in  = '0;
            end
         end
         ST_FINISH: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state, step count and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   // A result loads only into an empty output register
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish_int || cmd.finish_fixed) |-> !rsp_valid_ff)
      else $error("result loaded over a pending result");

   // The division runs exactly FRAC_BITS steps before the fixed result
   a_div_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |-> $past(state_ff, FRAC_BITS + 1) == ST_IDLE)
      else $error("fraction division length wrong");

   // No input transfer while the divider is busy
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready)
      else $error("input taken during division");

   // A new result follows a terminator or the end of a division
   a_valid_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.finish_int || cmd.finish_fixed))
      else $error("result valid without a source");
`endif

endmodule

### rtl/core/dttn_datapath.sv
// Datapath for the decimal text to number block: parse state, accumulators,
// restoring fraction divider and result register. Uses dttn_pkg.
`timescale 1ns / 1ps

module dttn_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [1:0]             csr_write_data,
   input  dttn_pkg::req_item_type req_data,
   input  dttn_pkg::cmd_type      cmd,
   output dttn_pkg::status_type   status,
   output dttn_pkg::rsp_item_type rsp_data
);
   import dttn_pkg::*;

   logic [1:0]                 mode_ff;
   logic                       at_start_ff, at_start_in;
   logic                       negative_ff, negative_in;
   logic                       in_fraction_ff, in_fraction_in;
   logic                       halted_ff, halted_in;
   logic                       saturated_ff, saturated_in;
   logic [INT_W-1:0]           int_acc_ff, int_acc_in;
   logic [FRAC_ACC_W-1:0]      frac_acc_ff, frac_acc_in;
   logic [FRAC_CNT_W-1:0]      frac_cnt_ff, frac_cnt_in;
   logic [FRAC_ACC_W-1:0]      rem_ff, rem_in;
   logic [FRAC_ACC_W-1:0]      divisor_ff;
   logic [FRAC_BITS-1:0]       quot_ff, quot_in;
   rsp_item_type               rsp_ff, rsp_in;

   logic                       fixed;
   logic [7:0]                 c;
   logic                       is_digit;
   logic [3:0]                 digit;
   logic [INT_W+3:0]           int_next;
   logic [FRAC_ACC_W:0]        rem_dbl;
   logic                       rem_ge;
   logic                       int_over;
   logic [MAG_W-1:0]           mag;
   logic [VALUE_W-1:0]         mag_ext;
   logic [INT_W-1:0]           int_signed;

   assign fixed             = mode_ff[1];
   assign status.fixed_mode = fixed;
   assign c                 = req_data.character;
   assign is_digit          = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   assign digit             = 4'(c - CHAR_ZERO);
   assign int_next          = {int_acc_ff, 3'b000} + {2'b00, int_acc_ff, 1'b0}
                              + (INT_W+4)'(digit);

   // Divider step: shift and conditionally subtract
   assign rem_dbl = {rem_ff, 1'b0};
   assign rem_ge  = (rem_dbl >= {1'b0, divisor_ff});

   // Fixed result magnitude from the clamped integer part and the quotient
   assign int_over   = (int_acc_ff > INT_MAX_FIXED);
   assign mag        = {(int_over ? INT_MAX_FIXED[30:0] : int_acc_ff[30:0]), quot_ff};
   assign mag_ext    = VALUE_W'(mag);
   assign int_signed = negative_ff ? (INT_W'(0) - int_acc_ff) : int_acc_ff;

   // Parse one character
   always_comb begin
      at_start_in    = at_start_ff;
      negative_in    = negative_ff;
      in_fraction_in = in_fraction_ff;
      halted_in      = halted_ff;
      saturated_in   = saturated_ff;
      int_acc_in     = int_acc_ff;
      frac_acc_in    = frac_acc_ff;
      frac_cnt_in    = frac_cnt_ff;
      if (cmd.take_char && !halted_ff) begin
         at_start_in = 1'b0;
         priority if (at_start_ff && (c == CHAR_MINUS || c == CHAR_PLUS)) begin
            if (c == CHAR_MINUS && mode_ff != MODE_UNSIGNED) begin
               negative_in = 1'b1;
            end
         end else if (is_digit) begin
            priority if (fixed && in_fraction_ff) begin
               if (frac_cnt_ff < FRAC_CNT_W'(MAX_FRAC_DIGITS)) begin
                  frac_acc_in = FRAC_ACC_W'({frac_acc_ff, 3'b000}
                                + {frac_acc_ff, 1'b0} + (FRAC_ACC_W+3)'(digit));
                  frac_cnt_in = frac_cnt_ff + 1'b1;
               end
            end else if (fixed) begin
               if (int_next > (INT_W+4)'(INT_MAX_FIXED)) begin
                  int_acc_in   = INT_MAX_FIXED;
                  saturated_in = 1'b1;
               end else begin
                  int_acc_in = int_next[INT_W-1:0];
               end
            end else begin
               int_acc_in = int_next[INT_W-1:0];
            end
         end else if (fixed && (c == CHAR_DOT || c == CHAR_COMMA) && !in_fraction_ff) begin
            in_fraction_in = 1'b1;
         end else begin
            halted_in = 1'b1;
         end
      end
      // Clear the parse once a result is formed
      if (cmd.finish_int || cmd.finish_fixed) begin
         at_start_in    = 1'b1;
         negative_in    = 1'b0;
         in_fraction_in = 1'b0;
         halted_in      = 1'b0;
         saturated_in   = 1'b0;
         int_acc_in     = '0;
         frac_acc_in    = '0;
         frac_cnt_in    = '0;
      end
   end

   // Divider next values
   always_comb begin
      rem_in  = rem_ff;
      quot_in = quot_ff;
      priority if (cmd.start_div) begin
         rem_in  = frac_acc_ff;
         quot_in = '0;
      end else if (cmd.div_step) begin
         rem_in  = rem_ge ? FRAC_ACC_W'(rem_dbl - {1'b0, divisor_ff}) : rem_dbl[FRAC_ACC_W-1:0];
         quot_in = {quot_ff[FRAC_BITS-2:0], rem_ge};
      end else begin
         rem_in  = rem_ff;
      end
   end

   // Form the result
   always_comb begin
      rsp_in = rsp_ff;
      priority if (cmd.finish_fixed) begin
         rsp_in.value            = negative_ff ? (VALUE_W'(0) - mag_ext) : mag_ext;
         rsp_in.integer_overflow = saturated_ff || int_over;
         rsp_in.stopped_early    = halted_ff;
      end else if (cmd.finish_int) begin
         if (mode_ff == MODE_UNSIGNED) begin
            rsp_in.value = VALUE_W'(int_acc_ff);
         end else begin
            rsp_in.value = {{(VALUE_W-INT_W){int_signed[INT_W-1]}}, int_signed};
         end
         rsp_in.integer_overflow = 1'b0;
         rsp_in.stopped_early    = halted_ff;
      end else begin
         rsp_in = rsp_ff;
      end
   end

   // Hold control and accumulator state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_SIGNED;
         at_start_ff    <= 1'b1;
         negative_ff    <= 1'b0;
         in_fraction_ff <= 1'b0;
         halted_ff      <= 1'b0;
         saturated_ff   <= 1'b0;
         int_acc_ff     <= '0;
         frac_acc_ff    <= '0;
         frac_cnt_ff    <= '0;
      end else begin
         if (csr_write_enable) begin
            mode_ff <= csr_write_data;
         end
         at_start_ff    <= at_start_in;
         negative_ff    <= negative_in;
         in_fraction_ff <= in_fraction_in;
         halted_ff      <= halted_in;
         saturated_ff   <= saturated_in;
         int_acc_ff     <= int_acc_in;
         frac_acc_ff    <= frac_acc_in;
         frac_cnt_ff    <= frac_cnt_in;
      end
   end

   // Divider and result payload
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      rsp_ff  <= rsp_in;
      if (cmd.start_div) begin
         divisor_ff <= pow10(frac_cnt_ff);
      end
   end

   assign rsp_data = rsp_ff;

endmodule

### rtl/core/decimal_text_to_number.sv
// Decimal text to number: one character per cycle while req_ready is high;
// the result comes on the end marker. Integer modes give it in the cycle after
// the terminator transfer; fixed mode first runs the restoring divider, one quotient
// bit per cycle, then a finish state. A terminator in fixed mode blocks input
// while the divider runs, and a terminator is held while a result still waits.
// Reset: synchronous, active high; clears the mode to signed integer and the parse.
`timescale 1ns / 1ps

module decimal_text_to_number (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  dttn_pkg::req_item_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output dttn_pkg::rsp_item_type rsp_data,
   input  logic                   csr_write_enable,
   input  logic [1:0]             csr_write_data
);
   import dttn_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequence transfers and the divider
   dttn_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_end_of_text (req_data.end_of_text),
      .req_ready       (req_ready),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .status          (status),
      .cmd             (cmd)
   );

   // Parse, divide and hold the result
   dttn_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_data         (req_data),
      .cmd              (cmd),
      .status           (status),
      .rsp_data         (rsp_data)
   );

endmodule
